// ===== rtl/fdf_pkg.sv =====
package fdf_pkg;

	// Number of recent message ids held for duplicate suppression.
	localparam int ID_STORE_DEPTH = 16;
	localparam int IDX_W = (ID_STORE_DEPTH > 1) ? $clog2(ID_STORE_DEPTH) : 1;
	localparam int CNT_W = $clog2(ID_STORE_DEPTH + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [31:0]      id_t;

	// Operation codes of an input item.
	localparam logic OP_RECEIVE   = 1'b0;
	localparam logic OP_ORIGINATE = 1'b1;

	// Configuration register indexes.
	localparam logic [7:0] CFG_PRICE_UPDATE_TYPE = 8'd0;
	localparam logic [7:0] CFG_MAX_TTL           = 8'd1;

	localparam logic [7:0] PRICE_UPDATE_TYPE_RESET = 8'd0;
	localparam logic [7:0] MAX_TTL_RESET           = 8'd3;
	localparam logic [7:0] PROMO_MASK              = 8'h01;

	// One access request to the id store: one read and one write port.
	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic wr_en;
		idx_t wr_addr;
		id_t  wr_data;
	} store_req_t;

endpackage

// ===== rtl/fdf_id_store.sv =====
module fdf_id_store import fdf_pkg::*; (
	input  logic       clk,
	input  store_req_t req,
	output id_t        rd_data
);

	// Entries hold no reset value; only slots below the fill count are read.
	id_t mem [ID_STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// ===== rtl/flood_relay_duplicate_filter.sv =====
// Duplicate filter and relay decision for a flooding mesh node.
// Input channel (in_valid/in_ready): one transfer carries a received packet
// (operation receive) or a locally originated message (operation originate).
// Output channel (out_valid/out_ready): exactly one result transfer per input
// item, in order, telling whether the id was a duplicate, whether a price
// update is handed to the application, and whether and with what TTL to relay.
// Configuration channel (cfg_valid/cfg_ready): always ready; index 0 sets the
// price update type code, index 1 the TTL of originated messages. Other
// indexes are ignored. Write configuration only while the block is idle.
// Throughput: one item at a time. A receive item scans the stored ids one per
// cycle through the single read port of the id store; the scan ends early when
// a duplicate is found. An originate item, or a receive item with an empty
// store, skips the scan. The next item is taken once the finish state has
// handed its result to the output register. A new id is written back before
// the finish state; a duplicate is not written back.
// Reset clears the store's fill count and write head, so all ids are
// forgotten at once, and restores the configuration defaults.
// When the receiver stalls, the result waits in the output register and the
// next input item is still taken; its result waits until the register frees.
module flood_relay_duplicate_filter import fdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// Input item channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] msg_id,
	input  logic [7:0]  hop_ttl,
	input  logic [7:0]  msg_type,
	input  logic [7:0]  flag_bits,
	input  logic [15:0] product_id,
	input  logic [31:0] price_cents,
	// Result channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic        duplicate,
	output logic        deliver_price,
	output logic [15:0] out_product_id,
	output logic [31:0] out_price_cents,
	output logic        promo,
	output logic        relay,
	output logic [7:0]  relay_ttl
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_WRITE  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	localparam idx_t LAST_IDX   = idx_t'(ID_STORE_DEPTH - 1);
	localparam cnt_t FULL_COUNT = cnt_t'(ID_STORE_DEPTH);

	logic [1:0] state_q;

	// Configuration registers.
	logic [7:0] price_type_q;
	logic [7:0] max_ttl_q;

	// Ring bookkeeping for the id store.
	idx_t head_q;
	cnt_t fill_q;

	// The item being worked on.
	logic        op_q;
	id_t         id_q;
	logic [7:0]  ttl_q;
	logic [7:0]  type_q;
	logic [7:0]  flags_q;
	logic [15:0] prod_q;
	logic [31:0] price_q;
	logic        hit_q;

	// Scan address counter and the read stage that follows it.
	cnt_t scan_q;
	logic valid_s1;
	logic last_s1;

	logic       out_valid_q;
	store_req_t req;
	id_t        rd_data;
	logic       issue;
	logic       out_free;

	fdf_id_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// A read goes out each scan cycle until every filled slot has been asked for.
	assign issue = (state_q == ST_SCAN) && (scan_q < fill_q);

	always_comb begin
		req.rd_en   = issue;
		req.rd_addr = scan_q[IDX_W-1:0];
		req.wr_en   = (state_q == ST_WRITE);
		req.wr_addr = head_q;
		req.wr_data = id_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			price_type_q <= PRICE_UPDATE_TYPE_RESET;
			max_ttl_q    <= MAX_TTL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PRICE_UPDATE_TYPE: price_type_q <= cfg_data;
				CFG_MAX_TTL:           max_ttl_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item payload is captured on the input transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= operation;
			id_q    <= msg_id;
			ttl_q   <= hop_ttl;
			type_q  <= msg_type;
			flags_q <= flag_bits;
			prod_q  <= product_id;
			price_q <= price_cents;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			fill_q   <= '0;
			scan_q   <= '0;
			hit_q    <= 1'b0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= issue;
			last_s1  <= (cnt_t'(scan_q + 1'b1) == fill_q);
			if (issue) begin
				scan_q <= cnt_t'(scan_q + 1'b1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						scan_q <= '0;
						hit_q  <= 1'b0;
						// Originated ids are recorded without a lookup.
						if (operation == OP_ORIGINATE || fill_q == '0) begin
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// The registered read data is compared in the cycle after its address.
					if (valid_s1 && rd_data == id_q) begin
						hit_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else if (valid_s1 && last_s1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					head_q <= (head_q == LAST_IDX) ? '0 : idx_t'(head_q + 1'b1);
					if (fill_q != FULL_COUNT) begin
						fill_q <= cnt_t'(fill_q + 1'b1);
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result fields; every field not set by its case reads as zero.
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			duplicate       <= 1'b0;
			deliver_price   <= 1'b0;
			out_product_id  <= '0;
			out_price_cents <= '0;
			promo           <= 1'b0;
			relay           <= 1'b0;
			relay_ttl       <= '0;
			priority if (op_q == OP_ORIGINATE) begin
				relay     <= 1'b1;
				relay_ttl <= max_ttl_q;
			end else if (hit_q) begin
				duplicate <= 1'b1;
			end else begin
				if (type_q == price_type_q) begin
					deliver_price   <= 1'b1;
					out_product_id  <= prod_q;
					out_price_cents <= price_q;
					promo           <= |(flags_q & PROMO_MASK);
				end
				if (ttl_q != '0) begin
					relay     <= 1'b1;
					relay_ttl <= ttl_q - 8'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/fdf_checker.sv =====
module fdf_checker import fdf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        duplicate,
	input logic        deliver_price,
	input logic [15:0] out_product_id,
	input logic [31:0] out_price_cents,
	input logic        promo,
	input logic        relay,
	input logic [7:0]  relay_ttl
);

	// A duplicate is dropped: nothing delivered and nothing relayed.
	a_dup_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && duplicate |-> !deliver_price && !relay)
		else $error("duplicate result carries a delivery or relay");

	// Without a delivery the price fields stay zero.
	a_no_deliver_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !deliver_price |->
			out_product_id == 16'd0 && out_price_cents == 32'd0 && !promo)
		else $error("price fields set without delivery");

	// Without a relay the relay TTL stays zero.
	a_no_relay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !relay |-> relay_ttl == 8'd0)
		else $error("relay ttl set without relay");

	// Items are worked one at a time: no transfer right after a transfer.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in consecutive cycles");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

endmodule

bind flood_relay_duplicate_filter fdf_checker u_fdf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.duplicate       (duplicate),
	.deliver_price   (deliver_price),
	.out_product_id  (out_product_id),
	.out_price_cents (out_price_cents),
	.promo           (promo),
	.relay           (relay),
	.relay_ttl       (relay_ttl)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the flooding mesh duplicate filter.
//
// Items go in over the in_valid/in_ready channel and results come back over
// out_valid/out_ready. Every item produces exactly one result. A predictor in
// this file keeps its own copy of the recent-id ring, its write head and fill
// count, and the two configuration registers. It works out the result of each
// item at the moment its transfer is seen. Results are checked in order
// against a queue of pending expectations.
//
// A short directed table runs first, under the reset configuration. It covers
// the field extremes, both operations, duplicates of received and originated
// ids, an originate whose id is already stored, a full ring that wraps and
// forgets its oldest id, and the promo bit. Rows whose result is obvious carry
// it typed in. The other rows use the predictor.
// Several random phases follow, each under new register values, the extremes
// among them. Writes to indexes the block does not decode are mixed in, and
// they must change nothing.
module testbench import fdf_pkg::*;;

	typedef struct packed {
		logic        op;
		logic [31:0] id;
		logic [7:0]  ttl;
		logic [7:0]  mtype;
		logic [7:0]  flags;
		logic [15:0] prod;
		logic [31:0] price;
	} mesh_item_t;

	typedef struct packed {
		logic        duplicate;
		logic        deliver;
		logic [15:0] prod;
		logic [31:0] price;
		logic        promo;
		logic        relay;
		logic [7:0]  relay_ttl;
	} relay_result_t;

	typedef struct packed {
		mesh_item_t    item;
		logic          known;
		relay_result_t want;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 23;
	localparam int ITEMS_PER_PHASE = 220;

	// Every DUT input gets a known value from time zero.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [7:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        operation = 1'b0;
	logic [31:0] msg_id = '0;
	logic [7:0]  hop_ttl = '0;
	logic [7:0]  msg_type = '0;
	logic [7:0]  flag_bits = '0;
	logic [15:0] product_id = '0;
	logic [31:0] price_cents = '0;
	logic        out_ready = 1'b0;

	logic        cfg_ready;
	logic        in_ready;
	logic        out_valid;
	logic        duplicate;
	logic        deliver_price;
	logic [15:0] out_product_id;
	logic [31:0] out_price_cents;
	logic        promo;
	logic        relay;
	logic [7:0]  relay_ttl;

	// The predictor's copy of the block's state and registers.
	logic [31:0] known_ids [ID_STORE_DEPTH];
	int          ring_head = 0;
	int          ring_fill = 0;
	logic [7:0]  price_type_reg = PRICE_UPDATE_TYPE_RESET;
	logic [7:0]  max_ttl_reg = MAX_TTL_RESET;

	relay_result_t pending_results [$];
	logic [31:0]   id_history [$];
	directed_row_t directed_table [DIRECTED_ROWS];

	// The chance of starting an idle burst, in percent. The receiver rolls for
	// it while not stalled; the sender rolls three times that before each item.
	int idle_pct = 0;
	int stall_left = 0;
	int fail_count = 0;

	flood_relay_duplicate_filter u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.msg_id          (msg_id),
		.hop_ttl         (hop_ttl),
		.msg_type        (msg_type),
		.flag_bits       (flag_bits),
		.product_id      (product_id),
		.price_cents     (price_cents),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.duplicate       (duplicate),
		.deliver_price   (deliver_price),
		.out_product_id  (out_product_id),
		.out_price_cents (out_price_cents),
		.promo           (promo),
		.relay           (relay),
		.relay_ttl       (relay_ttl)
	);

	always #4 clk = ~clk;

	// Predicts the result of one accepted item and updates the predictor state.
	// Only the first ring_fill slots take part in the lookup, so a slot that was
	// never written is never compared.
	function automatic relay_result_t relay_decision(mesh_item_t it);
		relay_result_t r;
		logic hit;
		r = '0;
		hit = 1'b0;
		if (it.op == OP_RECEIVE) begin
			for (int i = 0; i < ID_STORE_DEPTH; i++) begin
				if (i < ring_fill && known_ids[i] == it.id)
					hit = 1'b1;
			end
		end
		if (hit) begin
			r.duplicate = 1'b1;
			return r;
		end
		// A new id takes the oldest slot once the ring is full.
		known_ids[ring_head] = it.id;
		ring_head = (ring_head == ID_STORE_DEPTH - 1) ? 0 : ring_head + 1;
		if (ring_fill < ID_STORE_DEPTH)
			ring_fill++;
		if (it.op == OP_ORIGINATE) begin
			// Local messages always go out, even with a hop limit of zero.
			r.relay = 1'b1;
			r.relay_ttl = max_ttl_reg;
			return r;
		end
		if (it.mtype == price_type_reg) begin
			r.deliver = 1'b1;
			r.prod = it.prod;
			r.price = it.price;
			r.promo = |(it.flags & PROMO_MASK);
		end
		if (it.ttl != 8'd0) begin
			r.relay = 1'b1;
			r.relay_ttl = it.ttl - 8'd1;
		end
		return r;
	endfunction

	// Random items lean on ids seen lately, so that duplicates, ids already
	// pushed out of the ring and originates of known ids come up often. The
	// type hits the configured price update code about half of the time.
	function automatic mesh_item_t random_item();
		mesh_item_t it;
		int sel;
		logic [31:0] r;
		it.op = ($urandom_range(0, 99) < 20) ? OP_ORIGINATE : OP_RECEIVE;
		sel = $urandom_range(0, 99);
		if (sel < 45 && id_history.size() != 0)
			it.id = id_history[$urandom_range(0, id_history.size() - 1)];
		else if (sel < 60)
			it.id = $urandom_range(0, 31);
		else if (sel < 65)
			it.id = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
		else
			it.id = $urandom();
		id_history.push_back(it.id);
		if (id_history.size() > 40)
			void'(id_history.pop_front());
		sel = $urandom_range(0, 99);
		if (sel < 15)
			it.ttl = 8'd0;
		else if (sel < 25)
			it.ttl = 8'd1;
		else if (sel < 35)
			it.ttl = 8'hFF;
		else
			it.ttl = 8'($urandom_range(0, 255));
		sel = $urandom_range(0, 99);
		if (sel < 50)
			it.mtype = price_type_reg;
		else if (sel < 60)
			it.mtype = price_type_reg ^ (8'h01 << $urandom_range(0, 7));
		else
			it.mtype = 8'($urandom_range(0, 255));
		it.flags = 8'($urandom_range(0, 255));
		r = $urandom();
		it.prod = r[15:0];
		it.price = $urandom();
		return it;
	endfunction

	// Drives one item from the falling edge and holds it until the transfer.
	// Valid is left high afterwards; the next item or idle cycle sets it.
	task automatic send_item(mesh_item_t it, logic known, relay_result_t want);
		relay_result_t predicted;
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= it.op;
		msg_id <= it.id;
		hop_ttl <= it.ttl;
		msg_type <= it.mtype;
		flag_bits <= it.flags;
		product_id <= it.prod;
		price_cents <= it.price;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = relay_decision(it);
		pending_results.push_back(known ? want : predicted);
	endtask

	task automatic maybe_gap();
		if ($urandom_range(0, 99) < 3 * idle_pct)
			repeat ($urandom_range(1, 15)) @(negedge clk) in_valid <= 1'b0;
	endtask

	task automatic write_reg(logic [7:0] index, logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (index == CFG_PRICE_UPDATE_TYPE)
			price_type_reg = value;
		else if (index == CFG_MAX_TTL)
			max_ttl_reg = value;
	endtask

	// One random phase. The input side goes quiet and every pending result
	// has to come back before the registers change. Each item yields a
	// result, so once the last result is out the block holds no work.
	task automatic run_phase(logic [7:0] price_type, logic [7:0] hop_limit,
			logic [7:0] stray_index, logic [7:0] stray_data, int pct);
		@(negedge clk);
		in_valid <= 1'b0;
		idle_pct = pct;
		while (pending_results.size() != 0)
			@(posedge clk);
		write_reg(CFG_PRICE_UPDATE_TYPE, price_type);
		// An index the block does not decode must leave both registers alone.
		write_reg(stray_index, stray_data);
		write_reg(CFG_MAX_TTL, hop_limit);
		@(negedge clk);
		cfg_valid <= 1'b0;
		repeat (ITEMS_PER_PHASE) begin
			maybe_gap();
			send_item(random_item(), 1'b0, '0);
		end
	endtask

	// The directed table runs under the reset values: price update type 0,
	// originate hop limit 3.
	initial begin
		directed_table[0] = '{'{OP_RECEIVE, 32'h0000_0000, 8'd0, 8'h00, 8'h00, 16'h0000,
			32'h0000_0000}, 1'b1, '{1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 8'd0}};
		directed_table[1] = '{'{OP_RECEIVE, 32'h0000_0000, 8'd5, 8'h00, 8'h01, 16'h1234,
			32'd99}, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 8'd0}};
		directed_table[2] = '{'{OP_RECEIVE, 32'hFFFF_FFFF, 8'hFF, 8'h00, 8'hFF, 16'hFFFF,
			32'hFFFF_FFFF}, 1'b1, '{1'b0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFE}};
		directed_table[3] = '{'{OP_RECEIVE, 32'hFFFF_FFFF, 8'd0, 8'hFF, 8'h00, 16'h0000,
			32'h0000_0000}, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 8'd0}};
		directed_table[4] = '{'{OP_ORIGINATE, 32'h1234_5678, 8'd0, 8'h00, 8'hFF, 16'h5555,
			32'h5555_5555}, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0, 1'b1, 8'd3}};
		directed_table[5] = '{'{OP_RECEIVE, 32'h1234_5678, 8'd9, 8'h00, 8'h01, 16'h0001,
			32'h0000_0001}, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 8'd0}};
		directed_table[6] = '{'{OP_RECEIVE, 32'h0000_0001, 8'd1, 8'hFF, 8'hFF, 16'hAAAA,
			32'hAAAA_AAAA}, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0, 1'b1, 8'd0}};
		directed_table[7] = '{'{OP_RECEIVE, 32'h0000_0002, 8'h80, 8'h00, 8'hFE, 16'h8000,
			32'h8000_0000}, 1'b1, '{1'b0, 1'b1, 16'h8000, 32'h8000_0000, 1'b0, 1'b1, 8'h7F}};
		// Originating an id that is already stored skips the lookup entirely.
		directed_table[8] = '{'{OP_ORIGINATE, 32'h0000_0001, 8'hFF, 8'h00, 8'h01, 16'h0101,
			32'h0101_0101}, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0, 1'b1, 8'd3}};
		// Ten fresh ids bring the ring to exactly full with the head back at slot 0.
		for (int k = 0; k < 10; k++)
			directed_table[9 + k] = '{'{OP_RECEIVE, 32'hA000_0000 + k, 8'(k), (k % 2) ? 8'h01 :
				8'h00, 8'(k * 3), 16'(k * 257), 32'(k * 1000)}, 1'b0, '0};
		// This id overwrites the oldest slot, which held id 0.
		directed_table[19] = '{'{OP_RECEIVE, 32'hA000_0010, 8'd2, 8'h00, 8'h01, 16'h7777,
			32'h7777_7777}, 1'b0, '0};
		// Id 0 has been forgotten, so it passes as new.
		directed_table[20] = '{'{OP_RECEIVE, 32'h0000_0000, 8'd0, 8'h00, 8'h00, 16'h0000,
			32'h0000_0000}, 1'b1, '{1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 8'd0}};
		directed_table[21] = '{'{OP_RECEIVE, 32'hFFFF_FFFF, 8'd4, 8'h00, 8'h01, 16'h4321,
			32'h0BAD_F00D}, 1'b0, '0};
		directed_table[22] = '{'{OP_RECEIVE, 32'hA000_0009, 8'd6, 8'h00, 8'h01, 16'h0009,
			32'h0000_0009}, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 8'd0}};
	end

	// The receiver stalls in bursts whose length is drawn at random.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 14);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Every result transfer is compared field by field with the oldest
	// pending expectation.
	always @(posedge clk) begin : check_results
		relay_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: result transfer with nothing pending", $realtime);
			end else begin
				want = pending_results.pop_front();
				if (duplicate !== want.duplicate || deliver_price !== want.deliver ||
						out_product_id !== want.prod || out_price_cents !== want.price ||
						promo !== want.promo || relay !== want.relay ||
						relay_ttl !== want.relay_ttl) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: expected dup=%0d deliver=%0d prod=%h price=%h promo=%0d relay=%0d ttl=%0d",
							$realtime, want.duplicate, want.deliver, want.prod,
							want.price, want.promo, want.relay, want.relay_ttl);
						$display("%0t: actual   dup=%0d deliver=%0d prod=%h price=%h promo=%0d relay=%0d ttl=%0d",
							$realtime, duplicate, deliver_price, out_product_id,
							out_price_cents, promo, relay, relay_ttl);
					end
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_pct = 8;
		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			maybe_gap();
			send_item(directed_table[row].item, directed_table[row].known,
				directed_table[row].want);
		end

		// Extremes first, then mid and random settings. The second phase runs
		// without idling, and so does the last one.
		run_phase(8'hFF, 8'hFF, 8'd2, 8'hA5, 10);
		run_phase(8'h00, 8'h00, 8'hFF, 8'hFF, 0);
		run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'h80,
			8'($urandom_range(0, 255)), 4);
		run_phase(8'h01, 8'h80, 8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)), 20);
		run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)), 0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// A stray extra result would show up during this wait.
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Several times the slowest correct run: every item waiting on the longest
	// scan, the longest sender gap and the longest receiver stall.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
